// ----- rtl/mpfb_pkg.sv -----
// mpfb_pkg: shared constants, item types, command codes and state enums
// for the page framebuffer rasterizer; no dependencies
package mpfb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int PAGE_COUNT    = 8;
  localparam int SCREEN_HEIGHT = PAGE_COUNT * 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int COORD_W       = 10;
  localparam int ERR_W         = 12;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_READ  = 3'd1,
    REQ_LINE  = 3'd2,
    REQ_RECT  = 3'd3,
    REQ_CIRC  = 3'd4,
    REQ_FILL  = 3'd5
  } req_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic [7:0] radius;
    logic       color;
  } in_item_t;

  typedef struct packed {
    logic pixel_value;
    logic in_range;
  } out_item_t;

  // one pixel operation from the rasterizer to the read-modify-write unit
  typedef struct packed {
    logic   valid;
    logic   wr;
    logic   col;
    coord_t x;
    coord_t y;
  } pix_req_t;

  typedef struct packed {
    logic done;
    logic bit_val;
    logic init;
  } pix_rsp_t;

  typedef enum logic [1:0] {
    R_CLEAR,
    R_IDLE,
    R_MOD
  } rmw_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX,
    S_LINE,
    S_RECT,
    S_CIRC,
    S_CSET,
    S_SPAN,
    S_DONE
  } ras_state_e;

  function automatic logic on_screen(coord_t x, coord_t y);
    return !x[COORD_W-1] && (x < SCREEN_WIDTH) && !y[COORD_W-1] && (y < SCREEN_HEIGHT);
  endfunction

endpackage

// ----- rtl/mpfb_ram.sv -----
// mpfb_ram: generic simple dual-port ram, one write and one registered read
// port; no dependencies
module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/mpfb_rmw.sv -----
// mpfb_rmw: read-modify-write of single pixels in the page store, with the
// clearing sweep after reset; uses mpfb_pkg and mpfb_ram
module mpfb_rmw
  import mpfb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pix_req_t req_i,
  output pix_rsp_t rsp_o
);

  rmw_state_e        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [2:0]        bidx_q, bidx_d;
  logic              wr_q, wr_d, col_q, col_d;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;
  logic [7:0]        mask;

  mpfb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    bidx_q <= bidx_d;
    wr_q   <= wr_d;
    col_q  <= col_d;
  end

  assign mask = 8'(1) << bidx_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    addr_d  = addr_q;
    bidx_d  = bidx_q;
    wr_d    = wr_q;
    col_d   = col_q;
    we      = 1'b0;
    waddr   = addr_q;
    wdata   = rdata;
    raddr   = addr_q;
    rsp_o   = '0;
    case (state_q)
      R_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
          state_d = R_IDLE;
        end
      end
      R_IDLE: begin
        rsp_o.init = 1'b1;
        if (req_i.valid) begin
          if (on_screen(req_i.x, req_i.y)) begin
            addr_d  = ADDR_W'(int'(req_i.y[7:3]) * SCREEN_WIDTH + int'(req_i.x[7:0]));
            raddr   = addr_d;
            bidx_d  = req_i.y[2:0];
            wr_d    = req_i.wr;
            col_d   = req_i.col;
            state_d = R_MOD;
          end else begin
            // off-screen pixel: dropped, reads as 0
            rsp_o.done = 1'b1;
          end
        end
      end
      R_MOD: begin
        rsp_o.init    = 1'b1;
        rsp_o.done    = 1'b1;
        rsp_o.bit_val = rdata[bidx_q];
        if (wr_q) begin
          we    = 1'b1;
          wdata = col_q ? (rdata | mask) : (rdata & ~mask);
        end
        state_d = R_IDLE;
      end
      default: state_d = R_IDLE;
    endcase
  end

  a_mod_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == R_MOD |-> $past(state_q) == R_IDLE)
    else $error("modify cycle without a preceding read");

  a_mod_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == R_MOD |=> state_q == R_IDLE)
    else $error("modify cycle did not complete");

  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == R_CLEAR |=> (state_q == R_CLEAR && clr_q == $past(clr_q) + 1'b1)
                           || state_q == R_IDLE)
    else $error("clearing sweep skipped an entry");

endmodule

// ----- rtl/mpfb_raster.sv -----
// mpfb_raster: command sequencer that serves single pixel reads and writes and
// walks lines, rectangles and outline or filled circles pixel by pixel; uses mpfb_pkg, drives mpfb_rmw
module mpfb_raster
  import mpfb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      res_valid_o,
  input  logic      res_free_i,
  output out_item_t res_o,
  output pix_req_t  pix_o,
  input  pix_rsp_t  pix_i
);

  ras_state_e state_q, state_d;
  req_e       cmd_q, cmd_d;
  logic       col_q, col_d;
  coord_t     cx_q, cx_d, cy_q, cy_d;
  coord_t     ex_q, ex_d, ey_q, ey_d;
  coord_t     x_q, x_d, y_q, y_d;
  coord_t     dx_q, dx_d, dy_q, dy_d;
  coord_t     a_q, a_d, b_q, b_d;
  logic       sx_q, sx_d, sy_q, sy_d;
  err_t       err_q, err_d, d_q, d_d;
  logic [2:0] k_q, k_d;
  logic       pix_q, pix_d, inr_q, inr_d;

  coord_t             xa, ya, xb, yb, diffx, diffy, px, py, half, off;
  logic signed [ERR_W:0] e2, mdy;
  logic               c1, c2;
  err_t               d_next;
  coord_t             a_next, b_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      x_q     <= x_d;
      y_q     <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  col_q <= col_d;
    cx_q  <= cx_d;   cy_q  <= cy_d;
    ex_q  <= ex_d;   ey_q  <= ey_d;
    dx_q  <= dx_d;   dy_q  <= dy_d;
    a_q   <= a_d;    b_q   <= b_d;
    sx_q  <= sx_d;   sy_q  <= sy_d;
    d_q   <= d_d;    k_q   <= k_d;
    pix_q <= pix_d;  inr_q <= inr_d;
  end

  assign xa    = $signed({2'b00, in_item_i.x_a});
  assign ya    = $signed({2'b00, in_item_i.y_a});
  assign xb    = $signed({2'b00, in_item_i.x_b});
  assign yb    = $signed({2'b00, in_item_i.y_b});
  assign diffx = xb - xa;
  assign diffy = yb - ya;

  // bresenham decisions both taken from the error before the step
  assign e2  = {err_q, 1'b0};
  assign mdy = -((ERR_W+1)'(dy_q));
  assign c1  = e2 > mdy;
  assign c2  = e2 < (ERR_W+1)'(dx_q);

  // midpoint circle step
  always_comb begin
    if (!d_q[ERR_W-1]) begin
      d_next = d_q + (ERR_W'(a_q - b_q) <<< 2) + err_t'(10);
      b_next = b_q - 1'b1;
    end else begin
      d_next = d_q + (ERR_W'(a_q) <<< 2) + err_t'(6);
      b_next = b_q;
    end
    a_next = a_q + 1'b1;
  end

  // outline point k: bit 2 swaps a and b, bits 0 and 1 pick the signs
  always_comb begin
    px   = k_q[2] ? b_q : a_q;
    py   = k_q[2] ? a_q : b_q;
    px   = k_q[0] ? cx_q - px : cx_q + px;
    py   = k_q[1] ? cy_q - py : cy_q + py;
    half = k_q[1] ? b_q : a_q;
    off  = k_q[1] ? a_q : b_q;
  end

  always_comb begin
    pix_o.valid = 1'b0;
    pix_o.wr    = (cmd_q != REQ_READ);
    pix_o.col   = col_q;
    pix_o.x     = x_q;
    pix_o.y     = y_q;
    case (state_q)
      S_PIX, S_LINE, S_RECT, S_SPAN: pix_o.valid = 1'b1;
      S_CIRC: begin
        pix_o.valid = 1'b1;
        pix_o.x     = px;
        pix_o.y     = py;
      end
      default: pix_o.valid = 1'b0;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE) && pix_i.init;
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{pixel_value: pix_q, in_range: inr_q};

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;  col_d = col_q;
    cx_d  = cx_q;   cy_d  = cy_q;
    ex_d  = ex_q;   ey_d  = ey_q;
    x_d   = x_q;    y_d   = y_q;
    dx_d  = dx_q;   dy_d  = dy_q;
    a_d   = a_q;    b_d   = b_q;
    sx_d  = sx_q;   sy_d  = sy_q;
    err_d = err_q;  d_d   = d_q;
    k_d   = k_q;
    pix_d = pix_q;  inr_d = inr_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_d = req_e'(in_item_i.req_type);
          col_d = in_item_i.color;
          pix_d = 1'b0;
          inr_d = 1'b0;
          x_d   = xa;
          y_d   = ya;
          cx_d  = xa;
          cy_d  = ya;
          case (in_item_i.req_type)
            REQ_WRITE, REQ_READ: state_d = S_PIX;
            REQ_LINE: begin
              dx_d    = diffx[COORD_W-1] ? -diffx : diffx;
              dy_d    = diffy[COORD_W-1] ? -diffy : diffy;
              err_d   = ERR_W'(dx_d) - ERR_W'(dy_d);
              sx_d    = (xb > xa);
              sy_d    = (yb > ya);
              ex_d    = xb;
              ey_d    = yb;
              state_d = S_LINE;
            end
            REQ_RECT: begin
              ex_d = xa + $signed({2'b00, in_item_i.rect_width}) - 1'b1;
              ey_d = ya + $signed({2'b00, in_item_i.rect_height}) - 1'b1;
              if (in_item_i.rect_width == '0 || in_item_i.rect_height == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = S_RECT;
              end
            end
            REQ_CIRC, REQ_FILL: begin
              a_d     = '0;
              b_d     = $signed({2'b00, in_item_i.radius});
              d_d     = err_t'(3) - (ERR_W'(b_d) <<< 1);
              k_d     = '0;
              state_d = (in_item_i.req_type == REQ_FILL) ? S_CSET : S_CIRC;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PIX: begin
        if (pix_i.done) begin
          inr_d   = on_screen(x_q, y_q);
          pix_d   = (cmd_q == REQ_READ) && pix_i.bit_val;
          state_d = S_DONE;
        end
      end
      S_LINE: begin
        if (pix_i.done) begin
          if (x_q == ex_q && y_q == ey_q) begin
            state_d = S_DONE;
          end else begin
            if (c1) begin
              x_d = sx_q ? x_q + 1'b1 : x_q - 1'b1;
            end
            if (c2) begin
              y_d = sy_q ? y_q + 1'b1 : y_q - 1'b1;
            end
            err_d = err_q - (c1 ? ERR_W'(dy_q) : '0) + (c2 ? ERR_W'(dx_q) : '0);
          end
        end
      end
      S_RECT: begin
        if (pix_i.done) begin
          if (x_q == ex_q) begin
            x_d = cx_q;
            y_d = y_q + 1'b1;
            if (y_q == ey_q) begin
              state_d = S_DONE;
            end
          end else begin
            x_d = x_q + 1'b1;
          end
        end
      end
      S_CSET: begin
        // span k: rows y-b, y+b at half width a, rows y-a, y+a at half width b
        x_d     = cx_q - half;
        ex_d    = cx_q + half;
        y_d     = k_q[0] ? cy_q + off : cy_q - off;
        state_d = S_SPAN;
      end
      S_SPAN, S_CIRC: begin
        if (pix_i.done) begin
          if (state_q == S_SPAN && x_q != ex_q) begin
            x_d = x_q + 1'b1;
          end else if ((state_q == S_SPAN && k_q != 3'd3) ||
                       (state_q == S_CIRC && k_q != 3'd7)) begin
            k_d     = k_q + 1'b1;
            state_d = (state_q == S_SPAN) ? S_CSET : S_CIRC;
          end else begin
            a_d = a_next;
            b_d = b_next;
            d_d = d_next;
            k_d = '0;
            if (a_next <= b_next) begin
              state_d = (state_q == S_SPAN) ? S_CSET : S_CIRC;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_no_req_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !pix_o.valid)
    else $error("pixel request outside a command");

  a_done_only_on_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.done |-> $past(pix_o.valid) || pix_o.valid)
    else $error("pixel completion without a request");

  a_res_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && cmd_q != REQ_READ |-> !res_o.pixel_value)
    else $error("pixel value set for a non-read command");

endmodule

// ----- rtl/monochrome_page_framebuffer_raster.sv -----
// monochrome_page_framebuffer_raster: top level, rasterizer, pixel
// read-modify-write unit and output register; uses mpfb_pkg
//
// After reset the block sweeps the whole page store to zero, one byte a cycle
// (STORE_BYTES bytes, 1024 at 128 x 64); in_ready_o stays low until then.
// Each item then walks its pixels one at a time through the store: a pixel on
// the screen is read from the registered ram in R_IDLE and, for a write,
// written back in R_MOD; an off-screen pixel is answered in R_IDLE. A line
// walks max(|dx|,|dy|)+1 pixels, a rectangle w*h, a circle outline eight
// pixels per midpoint step and a filled circle four spans per step, each span
// a set-up state (S_CSET) plus its pixels.
// One item is in work at a time; its result sits in an output register.
module monochrome_page_framebuffer_raster
  import mpfb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  pix_req_t  pix_req;
  pix_rsp_t  pix_rsp;
  logic      res_valid, res_free;
  out_item_t res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  mpfb_raster u_raster (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .res_valid_o(res_valid),
    .res_free_i (res_free),
    .res_o      (res),
    .pix_o      (pix_req),
    .pix_i      (pix_rsp)
  );

  mpfb_rmw u_rmw (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (pix_req),
    .rsp_o (pix_rsp)
  );

  assign res_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (res_valid && res_free) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> pix_rsp.init)
    else $error("item accepted during the clearing sweep");

  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_free |=> out_valid_q)
    else $error("result dropped");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

endmodule
